@@ src/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assertion macros
// concurrent checks on clk, empty bodies when built for synthesis
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// check that is switched off while reset is held
`define FSP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// check that also holds through reset
`define FSP_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FSP_ASSERT(lbl, prop, msg)
`define FSP_ASSERT_RST(lbl, prop, msg)
`endif

`endif

@@ src/fsp_pkg.sv @@
// ---------------------------------------------------------------------------
// fsp_pkg
// shared constants and queue entry type of the format spec parser
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fsp_pkg;

  localparam int FIELD_MAX_DEF = 65535;

  localparam int STAR_W = 32;

  // result kinds
  localparam logic [1:0] K_LIT     = 2'd0;
  localparam logic [1:0] K_SPEC    = 2'd1;
  localparam logic [1:0] K_END_OK  = 2'd2;
  localparam logic [1:0] K_END_ERR = 2'd3;

  // flag bits
  localparam logic [5:0] F_LEFT  = 6'h01;
  localparam logic [5:0] F_PLUS  = 6'h02;
  localparam logic [5:0] F_SPACE = 6'h04;
  localparam logic [5:0] F_ZERO  = 6'h08;
  localparam logic [5:0] F_THOU  = 6'h10;
  localparam logic [5:0] F_HASH  = 6'h20;

  // length modifiers
  localparam logic [3:0] LEN_NONE = 4'd0;
  localparam logic [3:0] LEN_HH   = 4'd1;
  localparam logic [3:0] LEN_H    = 4'd2;
  localparam logic [3:0] LEN_L    = 4'd3;
  localparam logic [3:0] LEN_LL   = 4'd4;
  localparam logic [3:0] LEN_BIGL = 4'd5;
  localparam logic [3:0] LEN_J    = 4'd6;
  localparam logic [3:0] LEN_Z    = 4'd7;
  localparam logic [3:0] LEN_T    = 4'd8;
  localparam logic [3:0] LEN_I    = 4'd9;
  localparam logic [3:0] LEN_I32  = 4'd10;
  localparam logic [3:0] LEN_I64  = 4'd11;

  // characters of interest
  localparam logic [7:0] CH_PCT   = "%";
  localparam logic [7:0] CH_MINUS = "-";
  localparam logic [7:0] CH_PLUS  = "+";
  localparam logic [7:0] CH_SPACE = " ";
  localparam logic [7:0] CH_ZERO  = "0";
  localparam logic [7:0] CH_NINE  = "9";
  localparam logic [7:0] CH_QUOTE = "'";
  localparam logic [7:0] CH_HASH  = "#";
  localparam logic [7:0] CH_STAR  = "*";
  localparam logic [7:0] CH_DOT   = ".";
  localparam logic [7:0] CH_BIGL  = "L";
  localparam logic [7:0] CH_J     = "j";
  localparam logic [7:0] CH_Z     = "z";
  localparam logic [7:0] CH_T     = "t";
  localparam logic [7:0] CH_L     = "l";
  localparam logic [7:0] CH_H     = "h";
  localparam logic [7:0] CH_BIGI  = "I";

  // classified request held in the queue
  typedef struct packed {
    logic [7:0]        ch;
    logic              is_end;
    logic              is_dig;
    logic [3:0]        dig;
    logic [STAR_W-1:0] star_val;   // clamped star argument, signed
    logic [STAR_W-1:0] star_mag;   // its magnitude
    logic              star_neg;
  } fsp_entry_t;

endpackage

`default_nettype wire

@@ src/format_spec_parser.sv @@
// ---------------------------------------------------------------------------
// format_spec_parser
// printf style format string parser: literals, conversion specs, end status
// ---------------------------------------------------------------------------
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------------------
//   in      | in_valid / in_ready  | ch, star_arg
//   out     | out_valid / out_ready| kind, out_byte, flag_set, field_width,
//           |                      | field_precision, length_code
//
// one byte per cycle sustained while results are taken: a request enters
// the queue at its accepting edge and the combinational parser step loads
// the output register; a held result stops the parser, the queue fills, then in_ready drops
// a full queue takes no request in the cycle it drains, leaving one bubble
// synchronous reset: queue empty, in_ready low, parser in literal phase, no result
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module format_spec_parser
  import fsp_pkg::*;
#(
  parameter int FIELD_MAX = FIELD_MAX_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         ch,
  input  logic signed [31:0] star_arg,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         kind,
  output logic [7:0]         out_byte,
  output logic [5:0]         flag_set,
  output logic signed [16:0] field_width,
  output logic signed [16:0] field_precision,
  output logic [3:0]         length_code
);

  // front to queue
  logic       push;
  logic       q_full;
  fsp_entry_t wr_entry;

  // queue to back
  logic       q_valid;
  logic       q_pop;
  fsp_entry_t rd_entry;
  logic [1:0] q_count;

  // end result decode for the checks below
  logic       end_kind;
  logic       end_empty;

  // classifier: byte decode and star clamp
  fsp_front #(
    .FIELD_MAX (FIELD_MAX)
  ) u_front (
    .ch       (ch),
    .star_arg (star_arg),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .q_full   (q_full),
    .push     (push),
    .entry    (wr_entry)
  );

  // decoupling queue
  fsp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (wr_entry),
    .full     (q_full),
    .pop      (q_pop),
    .rd_valid (q_valid),
    .rd_entry (rd_entry),
    .count    (q_count)
  );

  // parser state machine with the result register
  fsp_back #(
    .FIELD_MAX (FIELD_MAX)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .q_valid         (q_valid),
    .q_entry         (rd_entry),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .kind            (kind),
    .out_byte        (out_byte),
    .flag_set        (flag_set),
    .field_width     (field_width),
    .field_precision (field_precision),
    .length_code     (length_code)
  );

  assign end_kind  = (kind == K_END_OK) || (kind == K_END_ERR);
  assign end_empty = (out_byte == 8'h00) && (length_code == LEN_NONE) && (flag_set == 6'h00);

  // queue occupancy never passes its depth
  `FSP_ASSERT(a_queue_depth, q_count != 2'd3, "queue occupancy beyond depth")

  // an end result carries no byte and no length
  `FSP_ASSERT(a_end_clean, out_valid && end_kind |-> end_empty, "end result with payload")

  // the terminator never leaks out as a literal
  `FSP_ASSERT(a_lit_nonzero, out_valid && kind == K_LIT |-> out_byte != 8'h00, "zero byte passed as literal")

  // reset leaves the queue empty and no result pending
  `FSP_ASSERT_RST(a_reset_empty, rst |=> q_count == 2'd0 && !out_valid, "state left after reset")

endmodule

`default_nettype wire

@@ src/fsp_front.sv @@
// ---------------------------------------------------------------------------
// fsp_front
// accepts requests, decodes digits and the terminator, clamps the star argument
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fsp_front
  import fsp_pkg::*;
#(
  parameter int FIELD_MAX = FIELD_MAX_DEF
) (
  input  logic [7:0]        ch,
  input  logic signed [31:0] star_arg,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              q_full,
  output logic              push,
  output fsp_entry_t        entry
);

  localparam logic signed [32:0] FM_POS = 33'(FIELD_MAX);
  localparam logic signed [32:0] FM_NEG = -33'(FIELD_MAX);

  logic signed [32:0] s_ext;
  logic signed [32:0] s_clamp;
  logic signed [32:0] s_abs;

  assign s_ext = {star_arg[31], star_arg};

  always_comb begin
    if (s_ext > FM_POS) begin
      s_clamp = FM_POS;
    end else if (s_ext < FM_NEG) begin
      s_clamp = FM_NEG;
    end else begin
      s_clamp = s_ext;
    end
    s_abs = s_clamp[32] ? -s_clamp : s_clamp;
  end

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    entry.ch       = ch;
    entry.is_end   = (ch == 8'h00);
    entry.is_dig   = (ch >= CH_ZERO) && (ch <= CH_NINE);
    entry.dig      = ch[3:0];
    entry.star_val = s_clamp[STAR_W-1:0];
    entry.star_mag = s_abs[STAR_W-1:0];
    entry.star_neg = s_clamp[32];
  end

endmodule

`default_nettype wire

@@ src/fsp_queue.sv @@
// ---------------------------------------------------------------------------
// fsp_queue
// two-entry queue between the classifier and the parser
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fsp_queue
  import fsp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  fsp_entry_t wr_entry,
  output logic       full,
  input  logic       pop,
  output logic       rd_valid,
  output fsp_entry_t rd_entry,
  output logic [1:0] count
);

  fsp_entry_t slot [2];
  logic       wr_ptr;
  logic       rd_ptr;

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // no request is taken while reset is held
  assign full     = (count == 2'd2) || rst;
  assign rd_valid = (count != 2'd0);
  assign rd_entry = slot[rd_ptr];

endmodule

`default_nettype wire

@@ src/fsp_back.sv @@
// ---------------------------------------------------------------------------
// fsp_back
// specifier state machine and registered result stage
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fsp_back
  import fsp_pkg::*;
#(
  parameter int FIELD_MAX = FIELD_MAX_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  fsp_entry_t        q_entry,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        kind,
  output logic [7:0]        out_byte,
  output logic [5:0]        flag_set,
  output logic signed [16:0] field_width,
  output logic signed [16:0] field_precision,
  output logic [3:0]        length_code
);

  // accumulator wide enough for +/- FIELD_MAX and the 17-bit result
  localparam int AW_NEED = $clog2(longint'(FIELD_MAX) + 1) + 1;
  localparam int AW      = (AW_NEED > 17) ? AW_NEED : 17;

  localparam logic [3:0] PH_LIT   = 4'd0;
  localparam logic [3:0] PH_FLAGS = 4'd1;
  localparam logic [3:0] PH_WDIG  = 4'd2;
  localparam logic [3:0] PH_PCHK  = 4'd3;
  localparam logic [3:0] PH_DOT   = 4'd4;
  localparam logic [3:0] PH_PDIG  = 4'd5;
  localparam logic [3:0] PH_LEN   = 4'd6;
  localparam logic [3:0] PH_AFT_L = 4'd7;
  localparam logic [3:0] PH_AFT_H = 4'd8;
  localparam logic [3:0] PH_AFT_I = 4'd9;
  localparam logic [3:0] PH_I_DIG = 4'd10;
  localparam logic [3:0] PH_TYPE  = 4'd11;
  localparam logic [3:0] PH_FAIL  = 4'd12;

  function automatic logic [AW-1:0] add_dig(input logic [AW-1:0] a, input logic [3:0] d);
    logic [AW+3:0] v;
    v = {1'b0, a, 3'b000} + {3'b000, a, 1'b0} + {{AW{1'b0}}, d};
    if (v > (AW + 4)'(FIELD_MAX)) begin
      return AW'(FIELD_MAX);
    end
    return v[AW-1:0];
  endfunction

  function automatic logic valid_type(input logic [7:0] c);
    case (c)
      "%", "d", "i", "u", "x", "X", "o", "f", "F", "e", "E", "g", "G",
      "a", "A", "s", "c", "p", "n": return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  logic [3:0]           phase;
  logic [5:0]           flag_bits;
  logic signed [AW-1:0] width_acc;
  logic signed [AW-1:0] prec_acc;
  logic [3:0]           length_held;
  logic [3:0]           first_digit;

  logic [3:0]           phase_next;
  logic [5:0]           flag_bits_next;
  logic signed [AW-1:0] width_acc_next;
  logic signed [AW-1:0] prec_acc_next;
  logic [3:0]           length_held_next;
  logic [3:0]           first_digit_next;

  logic                 emit;
  logic [1:0]           e_kind;
  logic [7:0]           e_byte;
  logic [5:0]           e_flags;
  logic [AW-1:0]        e_w;
  logic [AW-1:0]        e_p;
  logic [3:0]           e_len;
  logic                 done;
  logic [7:0]           c;

  assign c     = q_entry.ch;
  assign q_pop = q_valid && (!out_valid || out_ready);

  // phases fall forward only, so one pass in phase order covers every chain
  always_comb begin
    phase_next       = phase;
    flag_bits_next   = flag_bits;
    width_acc_next   = width_acc;
    prec_acc_next    = prec_acc;
    length_held_next = length_held;
    first_digit_next = first_digit;
    done    = 1'b0;
    emit    = 1'b0;
    e_kind  = K_LIT;
    e_byte  = c;
    e_flags = '0;
    e_w     = '1;
    e_p     = '1;
    e_len   = LEN_NONE;

    if (q_entry.is_end) begin
      emit             = 1'b1;
      e_kind           = (phase == PH_LIT) ? K_END_OK : K_END_ERR;
      e_byte           = 8'h00;
      phase_next       = PH_LIT;
      flag_bits_next   = '0;
      width_acc_next   = '1;
      prec_acc_next    = '1;
      length_held_next = LEN_NONE;
      first_digit_next = '0;
      done             = 1'b1;
    end

    if (!done && phase_next == PH_LIT) begin
      if (c == CH_PCT) begin
        flag_bits_next   = '0;
        width_acc_next   = '1;
        prec_acc_next    = '1;
        length_held_next = LEN_NONE;
        first_digit_next = '0;
        phase_next       = PH_FLAGS;
      end else begin
        emit = 1'b1;
      end
      done = 1'b1;
    end

    if (!done && phase_next == PH_FLAGS) begin
      done = 1'b1;
      case (c)
        CH_MINUS: flag_bits_next = flag_bits_next | F_LEFT;
        CH_PLUS:  flag_bits_next = flag_bits_next | F_PLUS;
        CH_SPACE: flag_bits_next = flag_bits_next | F_SPACE;
        CH_ZERO:  flag_bits_next = flag_bits_next | F_ZERO;
        CH_QUOTE: flag_bits_next = flag_bits_next | F_THOU;
        CH_HASH:  flag_bits_next = flag_bits_next | F_HASH;
        default:  done = 1'b0;
      endcase
      if (!done) begin
        if ((flag_bits_next & F_LEFT) != '0) begin
          flag_bits_next = flag_bits_next & ~F_ZERO;
        end
        if (c == CH_STAR) begin
          width_acc_next = q_entry.star_mag[AW-1:0];
          if (q_entry.star_neg) begin
            flag_bits_next = flag_bits_next | F_LEFT;
          end
          phase_next = PH_PCHK;
          done       = 1'b1;
        end else if (q_entry.is_dig) begin
          width_acc_next = add_dig('0, q_entry.dig);
          phase_next     = PH_WDIG;
          done           = 1'b1;
        end else begin
          phase_next = PH_PCHK;
        end
      end
    end

    if (!done && phase_next == PH_WDIG) begin
      if (q_entry.is_dig) begin
        width_acc_next = add_dig(width_acc_next, q_entry.dig);
        done           = 1'b1;
      end else begin
        phase_next = PH_PCHK;
      end
    end

    if (!done && phase_next == PH_PCHK) begin
      if (c == CH_DOT) begin
        phase_next = PH_DOT;
        done       = 1'b1;
      end else begin
        phase_next = PH_LEN;
      end
    end

    if (!done && phase_next == PH_DOT) begin
      if (c == CH_STAR) begin
        prec_acc_next = q_entry.star_val[AW-1:0];
        phase_next    = PH_LEN;
        done          = 1'b1;
      end else if (q_entry.is_dig) begin
        prec_acc_next = add_dig('0, q_entry.dig);
        phase_next    = PH_PDIG;
        done          = 1'b1;
      end else begin
        prec_acc_next = '0;
        phase_next    = PH_LEN;
      end
    end

    if (!done && phase_next == PH_PDIG) begin
      if (q_entry.is_dig) begin
        prec_acc_next = add_dig(prec_acc_next, q_entry.dig);
        done          = 1'b1;
      end else begin
        phase_next = PH_LEN;
      end
    end

    if (!done && phase_next == PH_LEN) begin
      done = 1'b1;
      case (c)
        CH_BIGL: begin
          length_held_next = LEN_BIGL;
          phase_next       = PH_TYPE;
        end
        CH_J: begin
          length_held_next = LEN_J;
          phase_next       = PH_TYPE;
        end
        CH_Z: begin
          length_held_next = LEN_Z;
          phase_next       = PH_TYPE;
        end
        CH_T: begin
          length_held_next = LEN_T;
          phase_next       = PH_TYPE;
        end
        CH_L: begin
          length_held_next = LEN_L;
          phase_next       = PH_AFT_L;
        end
        CH_H: begin
          length_held_next = LEN_H;
          phase_next       = PH_AFT_H;
        end
        CH_BIGI: begin
          length_held_next = LEN_I;
          phase_next       = PH_AFT_I;
        end
        default: begin
          phase_next = PH_TYPE;
          done       = 1'b0;
        end
      endcase
    end

    if (!done && phase_next == PH_AFT_L) begin
      if (c == CH_L) begin
        length_held_next = LEN_LL;
        done             = 1'b1;
      end
      phase_next = PH_TYPE;
    end

    if (!done && phase_next == PH_AFT_H) begin
      if (c == CH_H) begin
        length_held_next = LEN_HH;
        done             = 1'b1;
      end
      phase_next = PH_TYPE;
    end

    if (!done && phase_next == PH_AFT_I) begin
      if (q_entry.is_dig && q_entry.dig != 4'd0) begin
        first_digit_next = q_entry.dig;
        phase_next       = PH_I_DIG;
        done             = 1'b1;
      end else begin
        phase_next = PH_TYPE;
      end
    end

    if (!done && phase_next == PH_I_DIG) begin
      done = 1'b1;
      // only the pairs 3,2 and 6,4 name a legal integer size
      if (q_entry.is_dig && first_digit_next == 4'd3 && q_entry.dig == 4'd2) begin
        length_held_next = LEN_I32;
        phase_next       = PH_TYPE;
      end else if (q_entry.is_dig && first_digit_next == 4'd6 && q_entry.dig == 4'd4) begin
        length_held_next = LEN_I64;
        phase_next       = PH_TYPE;
      end else begin
        phase_next = PH_FAIL;
      end
    end

    if (!done && phase_next == PH_TYPE) begin
      done = 1'b1;
      if (valid_type(c)) begin
        emit             = 1'b1;
        e_kind           = K_SPEC;
        e_flags          = flag_bits_next;
        e_w              = width_acc_next;
        e_p              = prec_acc_next;
        e_len            = length_held_next;
        flag_bits_next   = '0;
        width_acc_next   = '1;
        prec_acc_next    = '1;
        length_held_next = LEN_NONE;
        first_digit_next = '0;
        phase_next       = PH_LIT;
      end else begin
        phase_next = PH_FAIL;
      end
    end

    // failed run and unused codes: swallow until the terminator
    if (!done) begin
      phase_next = PH_FAIL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_LIT;
      flag_bits   <= '0;
      width_acc   <= '1;
      prec_acc    <= '1;
      length_held <= LEN_NONE;
      first_digit <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (q_pop) begin
        phase       <= phase_next;
        flag_bits   <= flag_bits_next;
        width_acc   <= width_acc_next;
        prec_acc    <= prec_acc_next;
        length_held <= length_held_next;
        first_digit <= first_digit_next;
        out_valid   <= emit;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && emit) begin
      kind            <= e_kind;
      out_byte        <= e_byte;
      flag_set        <= e_flags;
      field_width     <= e_w[16:0];
      field_precision <= e_p[16:0];
      length_code     <= e_len;
    end
  end

endmodule

`default_nettype wire

@@ tb/tb_format_spec_parser.sv @@
// ---------------------------------------------------------------------------
// tb_format_spec_parser
// self-checking bench: format strings streamed in byte by byte, every parsed
// token checked against a cycle-free model of the parser or the directed table,
// under varying sender gaps and receiver stalls
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_format_spec_parser;
  import fsp_pkg::*;

  localparam int FMAX            = FIELD_MAX_DEF;
  localparam int HOLD_CYCLES     = 300;   // long receiver hold-off
  localparam int WATCHDOG_CYCLES = 5000;  // cycles with no handshake at all
  localparam int PHASE_REQS      = 325;   // minimum requests per idling phase

  localparam logic [7:0] CH_NUL = 8'd0;
  localparam logic signed [16:0] NO_FIELD = -17'sd1;

  // parser phases of the model
  typedef enum logic [3:0] {
    ST_LIT, ST_FLAGS, ST_WDIG, ST_PCHK, ST_DOT, ST_PDIG, ST_LEN,
    ST_AFT_L, ST_AFT_H, ST_AFT_I, ST_I_DIG, ST_TYPE, ST_FAIL
  } parse_state_t;

  // one parsed token as it leaves the block
  typedef struct packed {
    logic [1:0]        kind;
    logic [7:0]        obyte;
    logic [5:0]        flags;
    logic signed [16:0] fwidth;
    logic signed [16:0] fprec;
    logic [3:0]        len;
  } token_t;

  // one input request
  typedef struct packed {
    logic [7:0]  ch;
    logic [31:0] star;
  } req_t;

  // directed table row: typed rows carry their token, the rest are predicted
  typedef struct packed {
    req_t   req;
    logic   typed;
    logic   has;
    token_t tok;
  } dir_row_t;

  localparam token_t NO_TOKEN = '{kind: K_LIT, obyte: 8'd0, flags: 6'd0,
                                  fwidth: NO_FIELD, fprec: NO_FIELD, len: LEN_NONE};

  // dut signals; the driven inputs are known from time zero
  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         ch = 8'd0;
  logic signed [31:0] star_arg = 32'sd0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         kind;
  logic [7:0]         out_byte;
  logic [5:0]         flag_set;
  logic signed [16:0] field_width;
  logic signed [16:0] field_precision;
  logic [3:0]         length_code;

  // bench state
  token_t      token_q[$];     // tokens still owed by the block
  req_t        fmt_q[$];       // format string being built
  dir_row_t    dir_rows[$];
  int unsigned mismatches = 0;
  int          run_phase = -1; // -1 while the directed table runs
  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;
  bit          long_hold_done = 1'b0;

  // model state of the parser
  parse_state_t pstate;
  logic [5:0]   spec_flags;
  int           spec_width;
  int           spec_prec;
  logic [3:0]   spec_len;
  int           i_first_digit;

  string flag_chars = "-+ 0'#";
  string conv_types = "%diuxXofFeEgGaAscpn";

  format_spec_parser #(
    .FIELD_MAX(FMAX)
  ) DUT (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .ch             (ch),
    .star_arg       (star_arg),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .kind           (kind),
    .out_byte       (out_byte),
    .flag_set       (flag_set),
    .field_width    (field_width),
    .field_precision(field_precision),
    .length_code    (length_code)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ------------------------------------------------------------------------
  // parser model
  // ------------------------------------------------------------------------

  function automatic void clear_spec();
    spec_flags    = 6'd0;
    spec_width    = -1;
    spec_prec     = -1;
    spec_len      = LEN_NONE;
    i_first_digit = 0;
  endfunction

  function automatic bit is_dec(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  // decimal accumulate, saturating at the field limit
  function automatic int add_dec(input int acc, input logic [7:0] c);
    int v;
    v = acc * 10 + int'(c - CH_ZERO);
    return (v > FMAX) ? FMAX : v;
  endfunction

  // star argument clamped to plus or minus the field limit
  function automatic int clamp_star(input logic signed [31:0] s);
    int v;
    v = s;
    if (v > FMAX) v = FMAX;
    if (v < -FMAX) v = -FMAX;
    return v;
  endfunction

  // one byte through the model; returns 1 when a token comes out
  function automatic bit parse_byte(input logic [7:0] c, input logic signed [31:0] s,
                                    output token_t t);
    int sval;
    int two_dig;
    t = NO_TOKEN;
    // terminator ends the string from any phase
    if (c == CH_NUL) begin
      t.kind = (pstate == ST_LIT) ? K_END_OK : K_END_ERR;
      pstate = ST_LIT;
      clear_spec();
      return 1'b1;
    end
    // phases that do not consume the byte fall through to the next pass
    repeat (16) begin
      case (pstate)
        ST_LIT: begin
          if (c == CH_PCT) begin
            clear_spec();
            pstate = ST_FLAGS;
            return 1'b0;
          end
          t.obyte = c;
          return 1'b1;
        end
        ST_FLAGS: begin
          case (c)
            CH_MINUS: begin spec_flags |= F_LEFT;  return 1'b0; end
            CH_PLUS:  begin spec_flags |= F_PLUS;  return 1'b0; end
            CH_SPACE: begin spec_flags |= F_SPACE; return 1'b0; end
            CH_ZERO:  begin spec_flags |= F_ZERO;  return 1'b0; end
            CH_QUOTE: begin spec_flags |= F_THOU;  return 1'b0; end
            CH_HASH:  begin spec_flags |= F_HASH;  return 1'b0; end
            default: ;
          endcase
          // left align overrides zero pad once the flags are over
          if ((spec_flags & F_LEFT) != 6'd0) spec_flags &= ~F_ZERO;
          if (c == CH_STAR) begin
            sval = clamp_star(s);
            if (sval < 0) begin
              sval = -sval;
              spec_flags |= F_LEFT;
            end
            spec_width = sval;
            pstate = ST_PCHK;
            return 1'b0;
          end
          if (is_dec(c)) begin
            spec_width = add_dec(0, c);
            pstate = ST_WDIG;
            return 1'b0;
          end
          pstate = ST_PCHK;
        end
        ST_WDIG: begin
          if (is_dec(c)) begin
            spec_width = add_dec(spec_width, c);
            return 1'b0;
          end
          pstate = ST_PCHK;
        end
        ST_PCHK: begin
          if (c == CH_DOT) begin
            pstate = ST_DOT;
            return 1'b0;
          end
          pstate = ST_LEN;
        end
        ST_DOT: begin
          if (c == CH_STAR) begin
            spec_prec = clamp_star(s);
            pstate = ST_LEN;
            return 1'b0;
          end
          spec_prec = 0;
          if (is_dec(c)) begin
            spec_prec = add_dec(0, c);
            pstate = ST_PDIG;
            return 1'b0;
          end
          pstate = ST_LEN;
        end
        ST_PDIG: begin
          if (is_dec(c)) begin
            spec_prec = add_dec(spec_prec, c);
            return 1'b0;
          end
          pstate = ST_LEN;
        end
        ST_LEN: begin
          case (c)
            CH_BIGL: begin spec_len = LEN_BIGL; pstate = ST_TYPE;  return 1'b0; end
            CH_J:    begin spec_len = LEN_J;    pstate = ST_TYPE;  return 1'b0; end
            CH_Z:    begin spec_len = LEN_Z;    pstate = ST_TYPE;  return 1'b0; end
            CH_T:    begin spec_len = LEN_T;    pstate = ST_TYPE;  return 1'b0; end
            CH_L:    begin spec_len = LEN_L;    pstate = ST_AFT_L; return 1'b0; end
            CH_H:    begin spec_len = LEN_H;    pstate = ST_AFT_H; return 1'b0; end
            CH_BIGI: begin spec_len = LEN_I;    pstate = ST_AFT_I; return 1'b0; end
            default: ;
          endcase
          pstate = ST_TYPE;
        end
        ST_AFT_L: begin
          if (c == CH_L) begin
            spec_len = LEN_LL;
            pstate = ST_TYPE;
            return 1'b0;
          end
          pstate = ST_TYPE;
        end
        ST_AFT_H: begin
          if (c == CH_H) begin
            spec_len = LEN_HH;
            pstate = ST_TYPE;
            return 1'b0;
          end
          pstate = ST_TYPE;
        end
        ST_AFT_I: begin
          // a nonzero digit commits to I32 / I64, anything else is plain I
          if (c > CH_ZERO && c <= CH_NINE) begin
            i_first_digit = int'(c - CH_ZERO);
            pstate = ST_I_DIG;
            return 1'b0;
          end
          pstate = ST_TYPE;
        end
        ST_I_DIG: begin
          if (!is_dec(c)) begin
            pstate = ST_FAIL;
            return 1'b0;
          end
          two_dig = i_first_digit * 10 + int'(c - CH_ZERO);
          if (two_dig == 32) spec_len = LEN_I32;
          else if (two_dig == 64) spec_len = LEN_I64;
          else begin
            pstate = ST_FAIL;
            return 1'b0;
          end
          pstate = ST_TYPE;
          return 1'b0;
        end
        ST_TYPE: begin
          case (c)
            "%", "d", "i", "u", "x", "X", "o", "f", "F", "e", "E", "g", "G",
            "a", "A", "s", "c", "p", "n": begin
              t.kind   = K_SPEC;
              t.obyte  = c;
              t.flags  = spec_flags;
              t.fwidth = spec_width[16:0];
              t.fprec  = spec_prec[16:0];
              t.len    = spec_len;
              clear_spec();
              pstate = ST_LIT;
              return 1'b1;
            end
            default: begin
              pstate = ST_FAIL;
              return 1'b0;
            end
          endcase
        end
        default: begin
          // failed run: swallow until the terminator
          pstate = ST_FAIL;
          return 1'b0;
        end
      endcase
    end
    return 1'b0;
  endfunction

  // ------------------------------------------------------------------------
  // stimulus generation
  // ------------------------------------------------------------------------

  function automatic void push_byte(input logic [7:0] c);
    fmt_q.push_back('{ch: c, star: $urandom});
  endfunction

  // star with a value biased towards the clamp and sign corners
  function automatic void push_star();
    logic [31:0] s;
    case ($urandom_range(0, 6))
      0: s = $urandom_range(0, 200);
      1: s = -$urandom_range(1, 200);
      2: s = 32'h8000_0000;
      3: s = 32'h7FFF_FFFF;
      4: s = FMAX - 1 + $urandom_range(0, 2);
      5: s = -(FMAX - 1 + $urandom_range(0, 2));
      default: s = $urandom;
    endcase
    fmt_q.push_back('{ch: CH_STAR, star: s});
  endfunction

  // decimal digits, mostly short, now and then long enough to saturate
  function automatic void push_digits(input bit lead_nonzero);
    int n;
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 7) : $urandom_range(1, 3);
    for (int i = 0; i < n; i++)
      push_byte(CH_ZERO + 8'((i == 0 && lead_nonzero) ? $urandom_range(1, 9)
                                                      : $urandom_range(0, 9)));
  endfunction

  // one random format string: literals and well formed specs with some noise
  function automatic void build_format();
    int n_tok;
    int nf;
    logic [7:0] c;
    n_tok = $urandom_range(1, 6);
    for (int k = 0; k < n_tok; k++) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5: begin
          c = 8'($urandom_range(1, 255));
          push_byte(c);
        end
        19: push_byte(8'($urandom_range(0, 255)));
        default: begin
          push_byte(CH_PCT);
          nf = $urandom_range(0, 3);
          for (int f = 0; f < nf; f++)
            push_byte(flag_chars[$urandom_range(0, 5)]);
          case ($urandom_range(0, 3))
            1: push_digits(1'b1);
            2: push_star();
            default: ;
          endcase
          case ($urandom_range(0, 4))
            1: push_byte(CH_DOT);
            2: begin push_byte(CH_DOT); push_digits(1'b0); end
            3: begin push_byte(CH_DOT); push_star(); end
            default: ;
          endcase
          case ($urandom_range(0, 15))
            0: begin push_byte(CH_H); push_byte(CH_H); end
            1: push_byte(CH_H);
            2: push_byte(CH_L);
            3: begin push_byte(CH_L); push_byte(CH_L); end
            4: push_byte(CH_BIGL);
            5: push_byte(CH_J);
            6: push_byte(CH_Z);
            7: push_byte(CH_T);
            8: push_byte(CH_BIGI);
            9: begin push_byte(CH_BIGI); push_byte("3"); push_byte("2"); end
            10: begin push_byte(CH_BIGI); push_byte("6"); push_byte("4"); end
            11: begin
              // I width that is usually wrong
              push_byte(CH_BIGI);
              push_byte(CH_ZERO + 8'($urandom_range(1, 9)));
              if ($urandom_range(0, 1) == 0) push_byte(CH_ZERO + 8'($urandom_range(0, 9)));
              else push_byte(8'($urandom_range(1, 255)));
            end
            default: ;
          endcase
          case ($urandom_range(0, 29))
            0, 1: push_byte(8'($urandom_range(1, 255)));
            2: push_byte(CH_NUL);
            default: push_byte(conv_types[$urandom_range(0, conv_types.len() - 1)]);
          endcase
        end
      endcase
    end
    push_byte(CH_NUL);
  endfunction

  function automatic void add_row(input logic [7:0] c, input logic [31:0] s);
    dir_rows.push_back('{req: '{ch: c, star: s}, typed: 1'b0, has: 1'b0, tok: NO_TOKEN});
  endfunction

  function automatic void add_typed(input logic [7:0] c, input bit has,
                                    input logic [1:0] k, input logic [7:0] b);
    token_t t;
    t = NO_TOKEN;
    t.kind  = k;
    t.obyte = b;
    dir_rows.push_back('{req: '{ch: c, star: 32'd0}, typed: 1'b1, has: has, tok: t});
  endfunction

  // ------------------------------------------------------------------------
  // sender side
  // ------------------------------------------------------------------------

  // offer one request, with random gaps ahead of it, and model it on acceptance
  task automatic offer_req(input req_t r, output bit has, output token_t t);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    ch       <= r.ch;
    star_arg <= r.star;
    do @(posedge clk); while (!in_ready);
    has = parse_byte(r.ch, r.star, t);
  endtask

  // sender pause until every owed token has come back
  task automatic drain_tokens();
    in_valid <= 1'b0;
    while (token_q.size() != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    token_t t;
    bit     has;
    req_t   r;
    int     sent;

    pstate = ST_LIT;
    clear_spec();

    // directed table
    add_typed("A", 1'b1, K_LIT, "A");            // literal straight after reset
    add_typed(8'hFF, 1'b1, K_LIT, 8'hFF);        // top byte value
    add_typed(CH_NUL, 1'b1, K_END_OK, 8'd0);     // clean end
    // zero flag, most negative star width, largest star precision, I64
    add_row(CH_PCT, 32'd0);
    add_row(CH_ZERO, 32'd0);
    add_row(CH_STAR, 32'h8000_0000);
    add_row(CH_DOT, 32'hFFFF_FFFF);
    add_row(CH_STAR, 32'h7FFF_FFFF);
    add_row(CH_BIGI, 32'd0);
    add_row("6", 32'd0);
    add_row("4", 32'd0);
    add_row("d", 32'd0);
    // saturating decimal width, then a bad type and a swallowed byte
    add_row(CH_PCT, 32'd0);
    repeat (5) add_row(CH_NINE, 32'd0);
    add_typed("Q", 1'b0, K_LIT, 8'd0);
    add_typed("x", 1'b0, K_LIT, 8'd0);
    add_typed(CH_NUL, 1'b1, K_END_ERR, 8'd0);
    // I followed by a lone digit
    add_row(CH_PCT, 32'd0);
    add_row(CH_BIGI, 32'd0);
    add_row("1", 32'd0);
    add_typed("x", 1'b0, K_LIT, 8'd0);
    add_typed(CH_NUL, 1'b1, K_END_ERR, 8'd0);
    // string ends inside a specifier
    add_row(CH_PCT, 32'd0);
    add_typed(CH_NUL, 1'b1, K_END_ERR, 8'd0);

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      offer_req(dir_rows[i].req, has, t);
      if (dir_rows[i].typed) begin
        if (dir_rows[i].has) token_q.push_back(dir_rows[i].tok);
      end else if (has) begin
        token_q.push_back(t);
      end
    end
    drain_tokens();

    // random strings over the idling phases
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 83; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 83; end
        default: begin gap_pct = 23; stall_pct = 23; end
      endcase
      run_phase = ph;
      sent = 0;
      while (sent < PHASE_REQS) begin
        build_format();
        while (fmt_q.size() != 0) begin
          r = fmt_q.pop_front();
          offer_req(r, has, t);
          if (has) token_q.push_back(t);
          sent++;
        end
      end
      drain_tokens();
    end

    // settle, then verdict
    repeat (20) @(posedge clk);
    if (mismatches == 0 && token_q.size() == 0) begin
      $display("tb_format_spec_parser OK");
    end else begin
      $display("tb_format_spec_parser NOT OK");
    end
    $finish;
  end

  // ------------------------------------------------------------------------
  // receiver side
  // ------------------------------------------------------------------------

  // random stalls, plus one long hold-off at the start of the first random
  // phase so that the queue fills and the input backs up
  initial begin : receiver
    forever begin
      @(posedge clk);
      if (rst) begin
        out_ready <= 1'b0;
      end else if (run_phase == 0 && !long_hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold_done = 1'b1;
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // compare each returned token with the oldest one owed
  token_t got_tok;
  token_t exp_tok;

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      got_tok = '{kind: kind, obyte: out_byte, flags: flag_set, fwidth: field_width,
                  fprec: field_precision, len: length_code};
      if (token_q.size() == 0) begin
        $error("token with none owed: kind %0d byte %0h", kind, out_byte);
        mismatches++;
      end else begin
        exp_tok = token_q.pop_front();
        if (got_tok.kind !== exp_tok.kind) begin
          $error("kind: expected %0d, got %0d", exp_tok.kind, got_tok.kind);
          mismatches++;
        end
        if (got_tok.obyte !== exp_tok.obyte) begin
          $error("out_byte: expected %0h, got %0h", exp_tok.obyte, got_tok.obyte);
          mismatches++;
        end
        if (got_tok.flags !== exp_tok.flags) begin
          $error("flag_set: expected %0h, got %0h", exp_tok.flags, got_tok.flags);
          mismatches++;
        end
        if (got_tok.fwidth !== exp_tok.fwidth) begin
          $error("field_width: expected %0d, got %0d", exp_tok.fwidth, got_tok.fwidth);
          mismatches++;
        end
        if (got_tok.fprec !== exp_tok.fprec) begin
          $error("field_precision: expected %0d, got %0d", exp_tok.fprec, got_tok.fprec);
          mismatches++;
        end
        if (got_tok.len !== exp_tok.len) begin
          $error("length_code: expected %0d, got %0d", exp_tok.len, got_tok.len);
          mismatches++;
        end
      end
    end
  end

  // watchdog: too long without any handshake on either side
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("tb_format_spec_parser NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
